// File: rtl/lrl_pkg.sv
package lrl_pkg;

   // Entry space and link encoding
   localparam int ENTRIES = 64;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int LINK_W  = IDX_W + 1;
   localparam int ENTRY_W = 6;
   localparam int CMD_W   = 3;

   localparam logic [LINK_W-1:0] NONE_MARK = LINK_W'(ENTRIES);

   // Command codes
   localparam logic [CMD_W-1:0] CMD_TOUCH      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_EVICT      = 3'd2;
   localparam logic [CMD_W-1:0] CMD_ITER_RESET = 3'd3;
   localparam logic [CMD_W-1:0] CMD_ITER_NEXT  = 3'd4;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [ENTRY_W-1:0] entry_index;
      logic               entry_present;
   } lrl_req_type;

   typedef struct packed {
      logic               found;
      logic [ENTRY_W-1:0] result_entry;
   } lrl_rsp_type;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      logic [LINK_W-1:0] data;
   } lrl_link_wr_type;

   typedef struct packed {
      logic              busy;
      logic [LINK_W-1:0] head;
      logic [LINK_W-1:0] tail;
      logic [LINK_W-1:0] iter;
   } lrl_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UNLINK,
      ST_PUSH_A,
      ST_PUSH_B,
      ST_ITER
   } lrl_state_type;

endpackage

// File: rtl/lrl_link_ram.sv
module lrl_link_ram (
   input  logic                            clock,
   input  lrl_pkg::lrl_link_wr_type        wr,
   input  logic [lrl_pkg::IDX_W-1:0]       rd_addr,
   output logic [lrl_pkg::LINK_W-1:0]      rd_data
);
   import lrl_pkg::*;

   logic [LINK_W-1:0] mem [ENTRIES];
   logic [LINK_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/lrl_seq.sv
module lrl_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  lrl_pkg::lrl_req_type        req,
   input  logic [lrl_pkg::LINK_W-1:0]  newer_rd,
   input  logic [lrl_pkg::LINK_W-1:0]  older_rd,
   output lrl_pkg::lrl_link_wr_type    newer_wr,
   output lrl_pkg::lrl_link_wr_type    older_wr,
   output logic [lrl_pkg::IDX_W-1:0]   rd_addr,
   output lrl_pkg::lrl_status_type     status
);
   import lrl_pkg::*;

   lrl_state_type      state_ff, state_in;
   logic [LINK_W-1:0]  head_ff, head_in;
   logic [LINK_W-1:0]  tail_ff, tail_in;
   logic [LINK_W-1:0]  iter_ff, iter_in;
   logic [ENTRIES-1:0] in_list_ff, in_list_in;
   logic [IDX_W-1:0]   ent_ff, ent_in;
   logic               touch_ff, touch_in;

   logic               accept;
   logic               have;
   logic [IDX_W-1:0]   req_idx;
   logic [LINK_W-1:0]  old_nb;
   logic [LINK_W-1:0]  new_nb;

   assign accept  = start && (state_ff == ST_IDLE);
   assign req_idx = IDX_W'(req.entry_index);
   assign have    = req.entry_present && (LINK_W'(req.entry_index) < NONE_MARK);
   // sanitize neighbor links as read back
   assign old_nb  = (older_rd < NONE_MARK) ? older_rd : NONE_MARK;
   assign new_nb  = (newer_rd < NONE_MARK) ? newer_rd : NONE_MARK;

   // read the entry's links (or the iterator's) in the accept cycle
   assign rd_addr = (req.cmd == CMD_ITER_NEXT) ? iter_ff[IDX_W-1:0] : req_idx;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req.cmd)
                  CMD_TOUCH: begin
                     if (have) begin
                        state_in = in_list_ff[req_idx] ? ST_UNLINK : ST_PUSH_A;
                     end
                  end
                  CMD_REMOVE: begin
                     if (have && in_list_ff[req_idx]) begin
                        state_in = ST_UNLINK;
                     end
                  end
                  CMD_ITER_NEXT: begin
                     if (iter_ff < NONE_MARK) begin
                        state_in = ST_ITER;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_UNLINK: state_in = touch_ff ? ST_PUSH_A : ST_IDLE;
         ST_PUSH_A: state_in = ST_PUSH_B;
         ST_PUSH_B: state_in = ST_IDLE;
         ST_ITER:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath: link writes and pointer updates
   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      iter_in    = iter_ff;
      in_list_in = in_list_ff;
      ent_in     = ent_ff;
      touch_in   = touch_ff;
      newer_wr   = '0;
      older_wr   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ent_in   = req_idx;
               touch_in = (req.cmd == CMD_TOUCH);
               if (req.cmd == CMD_ITER_RESET) begin
                  iter_in = tail_ff;
               end
            end
         end
         ST_UNLINK: begin
            // step the iterator off the entry being unlinked
            if (iter_ff == LINK_W'(ent_ff)) begin
               iter_in = new_nb;
            end
            if (new_nb != NONE_MARK) begin
               older_wr.en   = 1'b1;
               older_wr.addr = new_nb[IDX_W-1:0];
               older_wr.data = old_nb;
            end else begin
               head_in = old_nb;
            end
            if (old_nb != NONE_MARK) begin
               newer_wr.en   = 1'b1;
               newer_wr.addr = old_nb[IDX_W-1:0];
               newer_wr.data = new_nb;
            end else begin
               tail_in = new_nb;
            end
            in_list_in[ent_ff] = 1'b0;
         end
         ST_PUSH_A: begin
            older_wr.en   = 1'b1;
            older_wr.addr = ent_ff;
            older_wr.data = head_ff;
            if (head_ff < NONE_MARK) begin
               newer_wr.en   = 1'b1;
               newer_wr.addr = head_ff[IDX_W-1:0];
               newer_wr.data = LINK_W'(ent_ff);
            end else begin
               tail_in = LINK_W'(ent_ff);
            end
            head_in            = LINK_W'(ent_ff);
            in_list_in[ent_ff] = 1'b1;
         end
         ST_PUSH_B: begin
            newer_wr.en   = 1'b1;
            newer_wr.addr = ent_ff;
            newer_wr.data = NONE_MARK;
         end
         ST_ITER: begin
            iter_in = new_nb;
         end
         default: begin
            iter_in = iter_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         head_ff    <= NONE_MARK;
         tail_ff    <= NONE_MARK;
         iter_ff    <= NONE_MARK;
         in_list_ff <= '0;
         touch_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         iter_ff    <= iter_in;
         in_list_ff <= in_list_in;
         touch_ff   <= touch_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   assign status.busy = (state_ff != ST_IDLE);
   assign status.head = head_ff;
   assign status.tail = tail_ff;
   assign status.iter = iter_ff;

endmodule

// File: rtl/lru_replacement_list.sv
// LRU replacement list: recency order over 64 entries kept as a doubly linked list.
// The result beat shows on rsp_strobe in the cycle after the command is taken.
// Evict, iterator reset and no-change commands leave the block idle; remove of a
// listed entry passes unlink, iterator next on an entry passes iter, and touch both
// push states, after unlink if listed. One write port per link RAM sets this order.
// Reset clears pointers and membership bits; the receiver cannot stall.
module lru_replacement_list (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  lrl_pkg::lrl_req_type  req_payload,
   output logic                  rsp_strobe,
   output lrl_pkg::lrl_rsp_type  rsp_payload
);
   import lrl_pkg::*;

   lrl_link_wr_type  newer_wr;
   lrl_link_wr_type  older_wr;
   logic [IDX_W-1:0] rd_addr;
   logic [LINK_W-1:0] newer_rd;
   logic [LINK_W-1:0] older_rd;
   lrl_status_type   status;

   logic             accept;
   logic             rsp_strobe_ff, rsp_strobe_in;
   lrl_rsp_type      rsp_ff, rsp_in;

   // Link RAMs: toward the head and toward the tail
   lrl_link_ram u_newer_ram (
      .clock   (clock),
      .wr      (newer_wr),
      .rd_addr (rd_addr),
      .rd_data (newer_rd)
   );

   lrl_link_ram u_older_ram (
      .clock   (clock),
      .wr      (older_wr),
      .rd_addr (rd_addr),
      .rd_data (older_rd)
   );

   // Sequencer: unlink, push front, iterator advance
   lrl_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req      (req_payload),
      .newer_rd (newer_rd),
      .older_rd (older_rd),
      .newer_wr (newer_wr),
      .older_wr (older_wr),
      .rd_addr  (rd_addr),
      .status   (status)
   );

   assign busy   = status.busy;
   assign accept = start && !busy;

   // Every command's result is known at accept: the tail for evict, the current
   // iterator position for iterator next, nothing otherwise. Register it as one beat.
   always_comb begin
      rsp_strobe_in = accept;
      rsp_in        = '0;
      case (req_payload.cmd)
         CMD_EVICT: begin
            if (status.tail < NONE_MARK) begin
               rsp_in.found        = 1'b1;
               rsp_in.result_entry = ENTRY_W'(status.tail[IDX_W-1:0]);
            end
         end
         CMD_ITER_NEXT: begin
            if (status.iter < NONE_MARK) begin
               rsp_in.found        = 1'b1;
               rsp_in.result_entry = ENTRY_W'(status.iter[IDX_W-1:0]);
            end
         end
         default: rsp_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   // One result beat for every accepted command, and none otherwise
   a_rsp_follows_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_strobe)
      else $error("missing result beat after accepted command");

   a_rsp_has_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy))
      else $error("result beat without accepted command");

   // Head and tail are empty together
   a_head_tail_empty: assert property (@(posedge clock) disable iff (reset)
      (status.head == NONE_MARK) == (status.tail == NONE_MARK))
      else $error("head and tail disagree on empty list");

endmodule

// File: sim/lru_replacement_list_checker.sv
module lru_replacement_list_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  lrl_pkg::lrl_req_type req_payload,
   input  logic                 rsp_strobe,
   input  lrl_pkg::lrl_rsp_type rsp_payload,
   output int                   fail_count,
   output int                   pending_count
);
   import lrl_pkg::*;

   // Shadow copy of the recency list: links toward head and tail, membership,
   // and the three pointers.
   logic [LINK_W-1:0] newer_of [ENTRIES];
   logic [LINK_W-1:0] older_of [ENTRIES];
   logic              listed   [ENTRIES];
   logic [LINK_W-1:0] newest;
   logic [LINK_W-1:0] oldest;
   logic [LINK_W-1:0] walk_pos;

   lrl_rsp_type expected_rsp_q [$];

   function automatic void unlink_slot(input logic [LINK_W-1:0] e);
      logic [LINK_W-1:0] o;
      logic [LINK_W-1:0] n;
      o = older_of[e[IDX_W-1:0]];
      n = newer_of[e[IDX_W-1:0]];
      if (walk_pos == e)
         walk_pos = n;
      if (n != NONE_MARK)
         older_of[n[IDX_W-1:0]] = o;
      else
         newest = o;
      if (o != NONE_MARK)
         newer_of[o[IDX_W-1:0]] = n;
      else
         oldest = n;
      listed[e[IDX_W-1:0]] = 1'b0;
   endfunction

   function automatic void push_newest(input logic [LINK_W-1:0] e);
      newer_of[e[IDX_W-1:0]] = NONE_MARK;
      older_of[e[IDX_W-1:0]] = newest;
      if (newest != NONE_MARK)
         newer_of[newest[IDX_W-1:0]] = e;
      else
         oldest = e;
      newest = e;
      listed[e[IDX_W-1:0]] = 1'b1;
   endfunction

   // Apply one command to the shadow list and return the beat it must produce.
   function automatic lrl_rsp_type apply_command(input lrl_req_type r);
      lrl_rsp_type       rsp;
      logic [LINK_W-1:0] e;
      rsp = '0;
      e   = LINK_W'(r.entry_index);
      case (r.cmd)
         CMD_TOUCH: begin
            if (r.entry_present) begin
               if (listed[r.entry_index])
                  unlink_slot(e);
               push_newest(e);
            end
         end
         CMD_REMOVE: begin
            if (r.entry_present && listed[r.entry_index])
               unlink_slot(e);
         end
         CMD_EVICT: begin
            if (oldest != NONE_MARK) begin
               rsp.found        = 1'b1;
               rsp.result_entry = oldest[ENTRY_W-1:0];
            end
         end
         CMD_ITER_RESET: begin
            walk_pos = oldest;
         end
         CMD_ITER_NEXT: begin
            if (walk_pos != NONE_MARK) begin
               rsp.found        = 1'b1;
               rsp.result_entry = walk_pos[ENTRY_W-1:0];
               walk_pos         = newer_of[walk_pos[IDX_W-1:0]];
            end
         end
         default: ;
      endcase
      return rsp;
   endfunction

   always @(posedge clock) begin
      lrl_rsp_type want;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            newer_of[i] = NONE_MARK;
            older_of[i] = NONE_MARK;
            listed[i]   = 1'b0;
         end
         newest   = NONE_MARK;
         oldest   = NONE_MARK;
         walk_pos = NONE_MARK;
         expected_rsp_q.delete();
      end else begin
         if (start && !busy)
            expected_rsp_q.push_back(apply_command(req_payload));
         if (rsp_strobe) begin
            if (expected_rsp_q.size() == 0) begin
               $display("%0t: unexpected result beat found=%0b entry=%0d", $time,
                        rsp_payload.found, rsp_payload.result_entry);
               fail_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_payload.found !== want.found) begin
                  $display("%0t: found mismatch, expected %0b actual %0b", $time,
                           want.found, rsp_payload.found);
                  fail_count++;
               end
               if (rsp_payload.result_entry !== want.result_entry) begin
                  $display("%0t: result_entry mismatch, expected %0d actual %0d", $time,
                           want.result_entry, rsp_payload.result_entry);
                  fail_count++;
               end
            end
         end
      end
      pending_count = expected_rsp_q.size();
   end

endmodule

// File: sim/lru_replacement_list_test.sv
module lru_replacement_list_test;
   import lrl_pkg::*;

   // Codes the block must treat as no-ops
   localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

   localparam int OPENING_LEN    = 26;
   localparam int TARGET_BEATS   = 1900;
   localparam int MAX_GAP        = 20;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int REQ_W          = $bits(lrl_req_type);

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   lrl_req_type req_payload;
   logic        rsp_strobe;
   lrl_rsp_type rsp_payload;

   int fail_count;
   int pending_count;
   int idle_pct;
   int beats_sent;
   int quiet_cycles;

   lru_replacement_list dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_strobe (rsp_strobe),
      .rsp_payload(rsp_payload)
   );

   lru_replacement_list_checker rsp_check (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_payload  (req_payload),
      .rsp_strobe   (rsp_strobe),
      .rsp_payload  (rsp_payload),
      .fail_count   (fail_count),
      .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog: count cycles in which neither a command nor a result beat moves.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL lru_replacement_list");
            $finish;
         end
      end
   end

   function automatic lrl_req_type make_req(input logic [CMD_W-1:0] c,
                                            input logic [ENTRY_W-1:0] idx,
                                            input logic present);
      lrl_req_type r;
      r.cmd           = c;
      r.entry_index   = idx;
      r.entry_present = present;
      return r;
   endfunction

   // Draw a command. With a narrow pool the indices stay in a set of eight
   // (picked by flip_mask) so touches hit listed entries and the iterator
   // keeps landing on entries that get unlinked under it.
   function automatic lrl_req_type random_req(input bit narrow,
                                              input logic [ENTRY_W-1:0] flip_mask);
      lrl_req_type r;
      int          pick;
      pick            = $urandom_range(99);
      r.entry_present = ($urandom_range(9) != 0);
      if (narrow)
         r.entry_index = ENTRY_W'($urandom_range(7)) ^ flip_mask;
      else
         r.entry_index = ENTRY_W'($urandom_range(ENTRIES - 1));
      if (pick < 40)
         r.cmd = CMD_TOUCH;
      else if (pick < 60)
         r.cmd = CMD_REMOVE;
      else if (pick < 70)
         r.cmd = CMD_EVICT;
      else if (pick < 77)
         r.cmd = CMD_ITER_RESET;
      else if (pick < 95)
         r.cmd = CMD_ITER_NEXT;
      else
         r.cmd = CMD_W'($urandom_range(CMD_SPARE_C, CMD_SPARE_A));
      return r;
   endfunction

   // Send one command beat. Before it, idle for a random number of cycles at
   // the current idle rate, scrambling the payload while start is low so the
   // block must ignore it. Hold start and the payload until busy drops at an edge.
   task automatic send_beat(input lrl_req_type r);
      int               gap;
      logic [REQ_W-1:0] noise;
      gap = 0;
      while (idle_pct > 0 && gap < MAX_GAP && $urandom_range(99) < idle_pct)
         gap++;
      if (gap > 0) begin
         noise = REQ_W'($urandom);
         @(negedge clock);
         start       <= 1'b0;
         req_payload <= noise;
         repeat (gap - 1) begin
            noise = REQ_W'($urandom);
            @(negedge clock);
            req_payload <= noise;
         end
      end
      @(negedge clock);
      start       <= 1'b1;
      req_payload <= r;
      do
         @(posedge clock);
      while (busy);
      beats_sent++;
   endtask

   initial begin
      lrl_req_type      opening_seq [OPENING_LEN];
      lrl_req_type      r;
      logic [ENTRY_W-1:0] flip_mask;
      int               phase_end;
      int               walk_len;

      // Empty-list queries, no-op commands, then a short list exercised through
      // touch of the tail, the iterator sitting on removed and re-touched
      // entries, and removal of tail, head and the last entry.
      opening_seq = '{
         make_req(CMD_EVICT,      6'd0,  1'b0),
         make_req(CMD_ITER_NEXT,  6'd0,  1'b0),
         make_req(CMD_ITER_RESET, 6'd0,  1'b0),
         make_req(CMD_ITER_NEXT,  6'd0,  1'b0),
         make_req(CMD_REMOVE,     6'd5,  1'b1),
         make_req(CMD_TOUCH,      6'd63, 1'b0),
         make_req(CMD_SPARE_A,    6'd63, 1'b1),
         make_req(CMD_TOUCH,      6'd0,  1'b1),
         make_req(CMD_TOUCH,      6'd63, 1'b1),
         make_req(CMD_TOUCH,      6'd21, 1'b1),
         make_req(CMD_TOUCH,      6'd42, 1'b1),
         make_req(CMD_TOUCH,      6'd0,  1'b1),
         make_req(CMD_EVICT,      6'd0,  1'b0),
         make_req(CMD_ITER_RESET, 6'd0,  1'b0),
         make_req(CMD_ITER_NEXT,  6'd0,  1'b0),
         make_req(CMD_REMOVE,     6'd21, 1'b1),
         make_req(CMD_ITER_NEXT,  6'd0,  1'b0),
         make_req(CMD_TOUCH,      6'd0,  1'b1),
         make_req(CMD_ITER_NEXT,  6'd0,  1'b0),
         make_req(CMD_REMOVE,     6'd42, 1'b0),
         make_req(CMD_SPARE_B,    6'd0,  1'b0),
         make_req(CMD_REMOVE,     6'd63, 1'b1),
         make_req(CMD_REMOVE,     6'd0,  1'b1),
         make_req(CMD_REMOVE,     6'd42, 1'b1),
         make_req(CMD_SPARE_C,    6'd42, 1'b1),
         make_req(CMD_EVICT,      6'd0,  1'b0)
      };

      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      idle_pct    = 0;
      beats_sent  = 0;

      // Hold reset, then drop it at a falling edge.
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (opening_seq[i])
         send_beat(opening_seq[i]);

      // Fill every slot, walk the full list past its end, then evict.
      for (int i = 0; i < ENTRIES; i++)
         send_beat(make_req(CMD_TOUCH, ENTRY_W'(i), 1'b1));
      send_beat(make_req(CMD_TOUCH, 6'd0, 1'b1));
      send_beat(make_req(CMD_ITER_RESET, 6'd0, 1'b0));
      repeat (ENTRIES + 1)
         send_beat(make_req(CMD_ITER_NEXT, 6'd0, 1'b0));
      send_beat(make_req(CMD_EVICT, 6'd0, 1'b0));

      // Random phases: no idling, heavy sender idling, light idling, none again.
      // Alternate between a narrow and the full index pool.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            1:       idle_pct = 67;
            2:       idle_pct = 13;
            default: idle_pct = 0;
         endcase
         flip_mask = ENTRY_W'($urandom_range(ENTRIES - 1));
         phase_end = beats_sent + (TARGET_BEATS - beats_sent) / (4 - phase);
         while (beats_sent < phase_end) begin
            if ($urandom_range(19) == 0) begin
               // Iterator sweep from the oldest entry, sometimes past the newest.
               walk_len = $urandom_range(24, 1);
               send_beat(make_req(CMD_ITER_RESET, 6'd0, 1'b0));
               repeat (walk_len)
                  send_beat(make_req(CMD_ITER_NEXT, 6'd0, 1'b0));
            end else begin
               r = random_req(phase[0], flip_mask);
               send_beat(r);
            end
         end
      end

      // Release start after the last beat, then drain.
      @(negedge clock);
      start <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_count == 0 && pending_count == 0)
         $display("PASS lru_replacement_list");
      else
         $display("FAIL lru_replacement_list");
      $finish;
   end

endmodule
